// ===== rtl/elfp_pkg.sv =====
// Shared types and constants for the ECHONET Lite frame parser.
// No dependencies; imported by every module of the block.
package elfp_pkg;

  localparam int unsigned HeaderLen = 12;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [CfgIdxW-1:0] CFG_EHD1 = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_EHD2 = 2'd1;

  localparam logic [7:0] EHD1_RESET = 8'h10;
  localparam logic [7:0] EHD2_RESET = 8'h81;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_EPC    = 3'd2,
    PH_PDC    = 3'd3,
    PH_DATA   = 3'd4,
    PH_DONE   = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PROP   = 2'd1,
    KIND_DATA   = 2'd2,
    KIND_BAD    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] transaction_id;
    logic [15:0] source_class;
    logic [7:0]  source_instance;
    logic [15:0] dest_class;
    logic [7:0]  dest_instance;
    logic [7:0]  service_code;
    logic [7:0]  count_value;
    logic [7:0]  property_code;
    logic [7:0]  payload_byte;
    logic [7:0]  property_number;
    logic        frame_last;
  } res_t;

endpackage

// ===== rtl/elfp_in_reg.sv =====
// Input register for one frame byte request.
// Depends on elfp_pkg.
module elfp_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  elfp_pkg::in_item_t item_i,
  output logic              valid_o,
  input  logic              adv_i,
  output elfp_pkg::in_item_t item_o
);
  import elfp_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;

  assign ready_o = !valid_q || adv_i;
  assign valid_d = (valid_i && ready_o) ? 1'b1 : (adv_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/elfp_parser.sv =====
// Frame state machine: header capture, property walk and result build.
// Depends on elfp_pkg.
module elfp_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  elfp_pkg::in_item_t item_i,
  input  logic [7:0]         ehd1_i,
  input  logic [7:0]         ehd2_i,
  output logic               res_valid_o,
  output elfp_pkg::res_t     res_o
);
  import elfp_pkg::*;

  phase_e      phase_q, phase_d, cur_phase;
  logic [3:0]  pos_q, pos_d, cur_pos;
  logic [15:0] tid_q, tid_d, cur_tid;
  logic [15:0] scls_q, scls_d, cur_scls;
  logic [7:0]  sins_q, sins_d, cur_sins;
  logic [15:0] dcls_q, dcls_d, cur_dcls;
  logic [7:0]  dins_q, dins_d, cur_dins;
  logic [7:0]  esv_q, esv_d, cur_esv;
  logic [7:0]  props_q, props_d, cur_props;
  logic [7:0]  dleft_q, dleft_d, cur_dleft;
  logic [7:0]  epc_q, epc_d, cur_epc;
  logic [7:0]  pidx_q, pidx_d, cur_pidx;
  logic [7:0]  b;
  logic [7:0]  dleft_dec;
  logic        prop_end_last;
  res_t        res;
  logic        res_valid;

  assign b = item_i.data_byte;

  always_comb begin
    cur_phase = phase_q;
    cur_pos   = pos_q;
    cur_tid   = tid_q;
    cur_scls  = scls_q;
    cur_sins  = sins_q;
    cur_dcls  = dcls_q;
    cur_dins  = dins_q;
    cur_esv   = esv_q;
    cur_props = props_q;
    cur_dleft = dleft_q;
    cur_epc   = epc_q;
    cur_pidx  = pidx_q;
    if (item_i.frame_start) begin
      cur_phase = PH_HEADER;
      cur_pos   = '0;
      cur_tid   = '0;
      cur_scls  = '0;
      cur_sins  = '0;
      cur_dcls  = '0;
      cur_dins  = '0;
      cur_esv   = '0;
      cur_props = '0;
      cur_dleft = '0;
      cur_epc   = '0;
      cur_pidx  = '0;
    end
  end

  assign dleft_dec     = cur_dleft - 8'd1;
  assign prop_end_last = (cur_props <= 8'd1);

  always_comb begin
    phase_d   = cur_phase;
    pos_d     = cur_pos;
    tid_d     = cur_tid;
    scls_d    = cur_scls;
    sins_d    = cur_sins;
    dcls_d    = cur_dcls;
    dins_d    = cur_dins;
    esv_d     = cur_esv;
    props_d   = cur_props;
    dleft_d   = cur_dleft;
    epc_d     = cur_epc;
    pidx_d    = cur_pidx;
    res_valid = 1'b0;

    res                 = '0;
    res.kind            = KIND_HEADER;
    res.transaction_id  = cur_tid;
    res.source_class    = cur_scls;
    res.source_instance = cur_sins;
    res.dest_class      = cur_dcls;
    res.dest_instance   = cur_dins;
    res.service_code    = cur_esv;

    unique case (cur_phase)
      PH_HEADER: begin
        pos_d = cur_pos + 4'd1;
        unique case (cur_pos)
          4'd0, 4'd1: begin
            if (b != ((cur_pos == 4'd0) ? ehd1_i : ehd2_i)) begin
              res            = '0;
              res.kind       = KIND_BAD;
              res.frame_last = 1'b1;
              res_valid      = 1'b1;
              phase_d        = PH_DONE;
            end
          end
          4'd2, 4'd3: tid_d  = {cur_tid[7:0], b};
          4'd4, 4'd5: scls_d = {cur_scls[7:0], b};
          4'd6:       sins_d = b;
          4'd7, 4'd8: dcls_d = {cur_dcls[7:0], b};
          4'd9:       dins_d = b;
          4'd10:      esv_d  = b;
          default: begin
            // property count closes the header
            props_d         = b;
            pidx_d          = '0;
            pos_d           = 4'(HeaderLen);
            res.count_value = b;
            res_valid       = 1'b1;
            if (b == 8'd0) begin
              res.frame_last = 1'b1;
              phase_d        = PH_DONE;
            end else begin
              phase_d = PH_EPC;
            end
          end
        endcase
      end
      PH_EPC: begin
        epc_d   = b;
        phase_d = PH_PDC;
      end
      PH_PDC: begin
        res.kind            = KIND_PROP;
        res.count_value     = b;
        res.property_code   = cur_epc;
        res.property_number = cur_pidx;
        res_valid           = 1'b1;
        if (b == 8'd0) begin
          res.frame_last = prop_end_last;
        end else begin
          dleft_d = b;
          phase_d = PH_DATA;
        end
      end
      PH_DATA: begin
        res.kind            = KIND_DATA;
        res.property_code   = cur_epc;
        res.payload_byte    = b;
        res.property_number = cur_pidx;
        res_valid           = 1'b1;
        dleft_d             = dleft_dec;
        if (dleft_dec == 8'd0) begin
          res.frame_last = prop_end_last;
        end
      end
      default: begin
      end
    endcase

    // end of property, shared by an empty PDC and the last data byte
    if ((cur_phase == PH_PDC && b == 8'd0) ||
        (cur_phase == PH_DATA && dleft_dec == 8'd0)) begin
      if (prop_end_last) begin
        props_d = '0;
        phase_d = PH_DONE;
      end else begin
        props_d = cur_props - 8'd1;
        pidx_d  = cur_pidx + 8'd1;
        phase_d = PH_EPC;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q   <= '0;
      tid_q   <= '0;
      scls_q  <= '0;
      sins_q  <= '0;
      dcls_q  <= '0;
      dins_q  <= '0;
      esv_q   <= '0;
      props_q <= '0;
      dleft_q <= '0;
      epc_q   <= '0;
      pidx_q  <= '0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      tid_q   <= tid_d;
      scls_q  <= scls_d;
      sins_q  <= sins_d;
      dcls_q  <= dcls_d;
      dins_q  <= dins_d;
      esv_q   <= esv_d;
      props_q <= props_d;
      dleft_q <= dleft_d;
      epc_q   <= epc_d;
      pidx_q  <= pidx_d;
    end
  end

  assign res_valid_o = res_valid;
  assign res_o       = res;

endmodule

// ===== rtl/echonet_lite_frame_parser_top.sv =====
// Top level of the ECHONET Lite frame parser: config registers, input
// register, parser and result register. Depends on elfp_pkg, elfp_in_reg,
// elfp_parser.
//
// Usage:
//   Frame bytes arrive on the in channel (in_valid_i/in_ready_o), one byte
//   per request, frame_start_i high on the first byte of a frame. Results
//   leave on the out channel (out_valid_o/out_ready_i): a header result
//   after the property count, one per property on its PDC byte, one per
//   EDT byte, or a bad-header result. frame_last_o marks the final one.
//   Bytes that cause no result are absorbed silently.
//   EHD1/EHD2 are written over the cfg channel (index 0 and 1); the port is
//   always ready, other indexes are dropped. Write only while idle.
//   An accepted byte waits in the input register; the parser takes it and
//   the result register loads once it is empty or being read.
//   Throughput: one byte per cycle while results are taken, limited by
//   back-pressure and by the single state update of the parser per byte.
//   When out_ready_i is low the result register holds; one more byte may
//   wait in the input register, after which in_ready_o drops.
//   Reset empties both registers, puts the parser in idle and loads the
//   default header values 0x10 and 0x81.
module echonet_lite_frame_parser_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [elfp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   data_byte_i,
  input  logic                         frame_start_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   kind_o,
  output logic [15:0]                  transaction_id_o,
  output logic [15:0]                  source_class_o,
  output logic [7:0]                   source_instance_o,
  output logic [15:0]                  dest_class_o,
  output logic [7:0]                   dest_instance_o,
  output logic [7:0]                   service_code_o,
  output logic [7:0]                   count_value_o,
  output logic [7:0]                   property_code_o,
  output logic [7:0]                   payload_byte_o,
  output logic [7:0]                   property_number_o,
  output logic                         frame_last_o
);
  import elfp_pkg::*;

  logic [7:0] ehd1_q, ehd2_q;
  in_item_t   in_item, s1_item;
  logic       s1_valid, adv;
  logic       res_valid;
  res_t       res, out_q;
  logic       out_valid_q, out_valid_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ehd1_q <= EHD1_RESET;
      ehd2_q <= EHD2_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_EHD1) begin
        ehd1_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_EHD2) begin
        ehd2_q <= cfg_data_i;
      end
    end
  end

  assign in_item.data_byte   = data_byte_i;
  assign in_item.frame_start = frame_start_i;

  elfp_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .item_i  (in_item),
    .valid_o (s1_valid),
    .adv_i   (adv),
    .item_o  (s1_item)
  );

  assign adv = s1_valid && (!out_valid_q || out_ready_i);

  elfp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .item_i      (s1_item),
    .ehd1_i      (ehd1_q),
    .ehd2_i      (ehd2_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_valid_d = adv ? res_valid : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = out_q.kind;
  assign transaction_id_o  = out_q.transaction_id;
  assign source_class_o    = out_q.source_class;
  assign source_instance_o = out_q.source_instance;
  assign dest_class_o      = out_q.dest_class;
  assign dest_instance_o   = out_q.dest_instance;
  assign service_code_o    = out_q.service_code;
  assign count_value_o     = out_q.count_value;
  assign property_code_o   = out_q.property_code;
  assign payload_byte_o    = out_q.payload_byte;
  assign property_number_o = out_q.property_number;
  assign frame_last_o      = out_q.frame_last;

endmodule

// ===== rtl/elfp_checker.sv =====
// Port-level checks on the frame parser results, bound to the top level.
// Depends on elfp_pkg and echonet_lite_frame_parser_top.
module elfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  kind_o,
  input logic [15:0] transaction_id_o,
  input logic [7:0]  count_value_o,
  input logic [7:0]  payload_byte_o,
  input logic        frame_last_o
);
  import elfp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) &&
      $stable(payload_byte_o) && $stable(frame_last_o))
    else $error("result changed while stalled");

  a_bad_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_BAD |-> frame_last_o && transaction_id_o == 16'd0)
    else $error("bad-header result not final or not cleared");

  a_empty_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_HEADER |-> frame_last_o == (count_value_o == 8'd0))
    else $error("header frame_last disagrees with property count");

  a_prop_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_PROP && count_value_o != 8'd0 |-> !frame_last_o)
    else $error("property with data marked as last");

endmodule

bind echonet_lite_frame_parser_top elfp_checker u_elfp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .kind_o           (kind_o),
  .transaction_id_o (transaction_id_o),
  .count_value_o    (count_value_o),
  .payload_byte_o   (payload_byte_o),
  .frame_last_o     (frame_last_o)
);

// ===== tb/echonet_lite_frame_parser_top_tb.sv =====
// Self-checking testbench for echonet_lite_frame_parser_top: frame bytes in, parse results out.
// It runs a directed table, then random frames under several header settings, with stalls on
// both channels. Depends on elfp_pkg and the parser RTL.
`timescale 1ns / 1ps

module echonet_lite_frame_parser_top_tb;
  import elfp_pkg::*;

  localparam int unsigned CycleLimit   = 800000;
  localparam int unsigned PhaseItems   = 282;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned HoldCycles   = 300;
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  typedef enum logic [1:0] {ROW_PRED, ROW_QUIET, ROW_BAD} row_e;
  typedef struct {
    logic [7:0] b;
    logic       s;
    row_e       how;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_byte = '0;
  logic in_start = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] kind;
  logic [15:0] transaction_id, source_class, dest_class;
  logic [7:0] source_instance, dest_instance, service_code, count_value;
  logic [7:0] property_code, payload_byte, property_number;
  logic frame_last;

  always #4 clk = ~clk;

  echonet_lite_frame_parser_top u_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .data_byte_i       (in_byte),
    .frame_start_i     (in_start),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .kind_o            (kind),
    .transaction_id_o  (transaction_id),
    .source_class_o    (source_class),
    .source_instance_o (source_instance),
    .dest_class_o      (dest_class),
    .dest_instance_o   (dest_instance),
    .service_code_o    (service_code),
    .count_value_o     (count_value),
    .property_code_o   (property_code),
    .payload_byte_o    (payload_byte),
    .property_number_o (property_number),
    .frame_last_o      (frame_last)
  );

  // parser state as predicted
  logic [7:0]  ehd1_cfg = EHD1_RESET;
  logic [7:0]  ehd2_cfg = EHD2_RESET;
  phase_e      ps_phase = PH_IDLE;
  logic [3:0]  ps_pos = '0;
  logic [15:0] tid_acc = '0, src_cls_acc = '0, dst_cls_acc = '0;
  logic [7:0]  src_inst_acc = '0, dst_inst_acc = '0, esv_acc = '0;
  logic [7:0]  props_left = '0, data_left = '0, epc_acc = '0, prop_idx = '0;

  res_t results_q[$];
  int unsigned fail_count = 0;
  int unsigned results_seen = 0;
  int unsigned items_done = 0;
  int unsigned cycles = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_done = 0;
  bit sender_burst = 1'b0;

  row_t dir_rows [24] = '{
    '{8'h3C, 1'b0, ROW_QUIET},       // byte while idle
    '{EHD1_RESET, 1'b1, ROW_QUIET},
    '{EHD2_RESET, 1'b0, ROW_QUIET},
    '{8'hFF, 1'b0, ROW_QUIET}, '{8'hFF, 1'b0, ROW_QUIET},
    '{8'h00, 1'b0, ROW_QUIET}, '{8'h00, 1'b0, ROW_QUIET},
    '{8'hFF, 1'b0, ROW_QUIET},
    '{8'hFF, 1'b0, ROW_QUIET}, '{8'hFF, 1'b0, ROW_QUIET},
    '{8'h00, 1'b0, ROW_QUIET},
    '{8'h62, 1'b0, ROW_QUIET},
    '{8'h02, 1'b0, ROW_PRED},        // OPC
    '{8'hFF, 1'b0, ROW_QUIET},
    '{8'h00, 1'b0, ROW_PRED},        // empty property
    '{8'h00, 1'b0, ROW_QUIET},
    '{8'h01, 1'b0, ROW_PRED},
    '{8'hFF, 1'b0, ROW_PRED},        // last EDT
    '{EHD1_RESET, 1'b0, ROW_QUIET},  // after frame complete
    '{8'h00, 1'b1, ROW_BAD},
    '{EHD2_RESET, 1'b0, ROW_QUIET},  // after error
    '{EHD1_RESET, 1'b1, ROW_QUIET},
    '{EHD1_RESET, 1'b1, ROW_QUIET},  // restart mid-frame
    '{8'hFF, 1'b0, ROW_BAD}
  };

  function automatic res_t frame_fields(input kind_e k);
    res_t r;
    r = '0;
    r.kind            = k;
    r.transaction_id  = tid_acc;
    r.source_class    = src_cls_acc;
    r.source_instance = src_inst_acc;
    r.dest_class      = dst_cls_acc;
    r.dest_instance   = dst_inst_acc;
    r.service_code    = esv_acc;
    return r;
  endfunction

  function automatic logic close_property();
    if (props_left <= 8'd1) begin
      props_left = '0;
      ps_phase = PH_DONE;
      return 1'b1;
    end
    props_left--;
    prop_idx++;
    ps_phase = PH_EPC;
    return 1'b0;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, input logic s, output res_t r);
    logic [3:0] pos;
    r = '0;
    if (s) begin
      ps_phase = PH_HEADER;
      ps_pos = '0;
      tid_acc = '0; src_cls_acc = '0; src_inst_acc = '0;
      dst_cls_acc = '0; dst_inst_acc = '0; esv_acc = '0;
      props_left = '0; data_left = '0; epc_acc = '0; prop_idx = '0;
    end
    case (ps_phase)
      PH_HEADER: begin
        pos = ps_pos;
        ps_pos = pos + 4'd1;
        case (pos)
          4'd0, 4'd1: begin
            if (b != ((pos == 4'd0) ? ehd1_cfg : ehd2_cfg)) begin
              r.kind = KIND_BAD;
              r.frame_last = 1'b1;
              ps_phase = PH_DONE;
              return 1'b1;
            end
          end
          4'd2, 4'd3: tid_acc = {tid_acc[7:0], b};
          4'd4, 4'd5: src_cls_acc = {src_cls_acc[7:0], b};
          4'd6: src_inst_acc = b;
          4'd7, 4'd8: dst_cls_acc = {dst_cls_acc[7:0], b};
          4'd9: dst_inst_acc = b;
          4'd10: esv_acc = b;
          default: begin
            props_left = b;
            prop_idx = '0;
            ps_pos = 4'(HeaderLen);
            r = frame_fields(KIND_HEADER);
            r.count_value = b;
            if (b == 8'd0) begin
              r.frame_last = 1'b1;
              ps_phase = PH_DONE;
            end else begin
              ps_phase = PH_EPC;
            end
            return 1'b1;
          end
        endcase
        return 1'b0;
      end
      PH_EPC: begin
        epc_acc = b;
        ps_phase = PH_PDC;
        return 1'b0;
      end
      PH_PDC: begin
        r = frame_fields(KIND_PROP);
        r.count_value = b;
        r.property_code = epc_acc;
        r.property_number = prop_idx;
        if (b == 8'd0) begin
          r.frame_last = close_property();
        end else begin
          data_left = b;
          ps_phase = PH_DATA;
        end
        return 1'b1;
      end
      PH_DATA: begin
        r = frame_fields(KIND_DATA);
        r.property_code = epc_acc;
        r.payload_byte = b;
        r.property_number = prop_idx;
        data_left--;
        if (data_left == 8'd0) r.frame_last = close_property();
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // one request on the byte channel, predicted on acceptance
  task automatic send_byte(input logic [7:0] b, input logic s, input row_e how);
    res_t r, bad;
    bit got;
    int unsigned gap, pick;
    in_valid <= 1'b1;
    in_byte  <= b;
    in_start <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (s || (ps_phase != PH_IDLE && ps_phase != PH_DONE)) items_done++;
    got = parse_byte(b, s, r);
    bad = '0;
    bad.kind = KIND_BAD;
    bad.frame_last = 1'b1;
    case (how)
      ROW_PRED: if (got) results_q.insert(results_q.size(), r);
      ROW_BAD:  results_q.insert(results_q.size(), bad);
      default: ;
    endcase
    pick = $urandom_range(99);
    if (sender_burst || pick < 55) gap = 0;
    else if (pick < 85) gap = $urandom_range(1, 3);
    else if (pick < 97) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 60);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_EHD1) ehd1_cfg = val;
    else if (idx == CFG_EHD2) ehd2_cfg = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (results_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic emit_frame();
    logic [7:0] seq_q[$];
    int unsigned sel, pick, opc, pdc, cut, k, j;
    sender_burst = ($urandom_range(3) == 0);
    sel = $urandom_range(99);
    if (sel < 7) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(7) == 0, ROW_PRED);
    end else if (sel < 14) begin
      if ($urandom_range(1) == 0) begin
        send_byte(ehd1_cfg ^ 8'($urandom_range(1, 255)), 1'b1, ROW_PRED);
      end else begin
        send_byte(ehd1_cfg, 1'b1, ROW_PRED);
        send_byte(ehd2_cfg ^ 8'($urandom_range(1, 255)), 1'b0, ROW_PRED);
      end
      repeat ($urandom_range(0, 4)) send_byte(8'($urandom), 1'b0, ROW_PRED);
    end else begin
      seq_q.insert(seq_q.size(), ehd1_cfg);
      seq_q.insert(seq_q.size(), ehd2_cfg);
      repeat (9) seq_q.insert(seq_q.size(), 8'($urandom));
      pick = $urandom_range(99);
      if (pick < 2) opc = 255;
      else if (pick < 20) opc = 0;
      else if (pick < 90) opc = $urandom_range(1, 3);
      else opc = $urandom_range(4, 12);
      seq_q.insert(seq_q.size(), 8'(opc));
      for (k = 0; k < opc; k++) begin
        seq_q.insert(seq_q.size(), 8'($urandom));
        pick = $urandom_range(99);
        if (pick < 2) pdc = 255;
        else if (pick < 20) pdc = 0;
        else if (pick < 90) pdc = $urandom_range(1, 4);
        else pdc = $urandom_range(5, 24);
        seq_q.insert(seq_q.size(), 8'(pdc));
        for (j = 0; j < pdc; j++) seq_q.insert(seq_q.size(), 8'($urandom));
        if (opc == 255 && seq_q.size() > 60) break;
      end
      // long property lists are always cut short
      if (opc == 255) cut = $urandom_range(13, 60);
      else if (sel < 26) cut = $urandom_range(1, seq_q.size() - 1);
      else cut = seq_q.size();
      for (k = 0; k < cut; k++) send_byte(seq_q[k], k == 0, ROW_PRED);
      if (cut == seq_q.size() && $urandom_range(7) == 0)
        send_byte(8'($urandom), 1'b0, ROW_PRED);
    end
  endtask

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (results_q.size() == 0) begin
        $error("result with none expected: kind %0d", kind);
        fail_count++;
      end else begin
        want = results_q.pop_front();
        check_field("kind", 16'(want.kind), 16'(kind));
        check_field("transaction_id", want.transaction_id, transaction_id);
        check_field("source_class", want.source_class, source_class);
        check_field("source_instance", 16'(want.source_instance), 16'(source_instance));
        check_field("dest_class", want.dest_class, dest_class);
        check_field("dest_instance", 16'(want.dest_instance), 16'(dest_instance));
        check_field("service_code", 16'(want.service_code), 16'(service_code));
        check_field("count_value", 16'(want.count_value), 16'(count_value));
        check_field("property_code", 16'(want.property_code), 16'(property_code));
        check_field("payload_byte", 16'(want.payload_byte), 16'(payload_byte));
        check_field("property_number", 16'(want.property_number), 16'(property_number));
        check_field("frame_last", 16'(want.frame_last), 16'(frame_last));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, results_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random back-pressure, plus a long hold-off on request
  initial begin : receiver
    int unsigned run, gap, pick, k;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (hold_asked != hold_done) begin
        out_ready <= 1'b0;
        for (k = 0; k < HoldCycles; k++) @(posedge clk);
        hold_done++;
      end else begin
        run = ($urandom_range(7) == 0) ? 200 : $urandom_range(1, 40);
        pick = $urandom_range(99);
        if (pick < 50) gap = 0;
        else if (pick < 85) gap = $urandom_range(1, 3);
        else if (pick < 96) gap = $urandom_range(4, 12);
        else gap = $urandom_range(20, 60);
        out_ready <= 1'b1;
        repeat (run) @(posedge clk);
        if (gap != 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned p, phase_start;
    logic [7:0] v1, v2;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) send_byte(dir_rows[i].b, dir_rows[i].s, dir_rows[i].how);
    for (p = 0; p < 4; p++) begin
      settle();
      case (p)
        0: begin v1 = 8'h00; v2 = 8'hFF; end
        1: begin v1 = 8'hFF; v2 = 8'h00; end
        2: begin v1 = 8'($urandom); v2 = 8'($urandom); end
        default: begin v1 = EHD1_RESET; v2 = EHD2_RESET; end
      endcase
      write_reg(CFG_EHD1, v1);
      write_reg(CFG_EHD2, v2);
      if (p == 2) write_reg(CfgSpare, 8'($urandom));
      hold_asked++;
      phase_start = items_done;
      while (items_done - phase_start < PhaseItems) emit_frame();
    end
    settle();
    if (results_q.size() != 0) begin
      $error("%0d expected results never arrived", results_q.size());
      fail_count++;
    end
    $display("%0d frame bytes parsed, %0d results compared under five header settings",
             items_done, results_seen);
    $display("%0d mismatches, %0d cycles", fail_count, cycles);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/elfp_pkg.sv
rtl/elfp_in_reg.sv
rtl/elfp_parser.sv
rtl/echonet_lite_frame_parser_top.sv
rtl/elfp_checker.sv
tb/echonet_lite_frame_parser_top_tb.sv
